[hw/rtl/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, constants and the arctangent table for the sample-to-pixel unit.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int DESCRIPTOR_BYTES_DEF = 7;
  localparam int CORDIC_STEPS_DEF     = 16;

  localparam int DESC_W     = 3;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_QUALITY_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SCAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE   = 3'd4;

  localparam logic [7:0]  QUALITY_MIN_RST    = 8'd8;
  localparam logic [11:0] SAMPLES_PER_SCAN_RST = 12'd2000;
  localparam logic [8:0]  CENTER_X_RST       = 9'd160;
  localparam logic [8:0]  CENTER_Y_RST       = 9'd120;
  localparam logic [19:0] DISTANCE_SCALE_RST = 20'd50332;

  // angles in 1/64 degree
  localparam logic [14:0] FULL_TURN     = 15'd23040;
  localparam logic [14:0] HALF_TURN     = 15'd11520;
  localparam logic [14:0] QUARTER_TURN  = 15'd5760;
  localparam logic [14:0] THREE_QUARTER = 15'd17280;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [17:0] Q16_ONE = 18'sd65536;
  localparam logic signed [10:0] PIX_MIN = -11'sd512;
  localparam logic signed [10:0] PIX_MAX = 11'sd767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROTATE,
    ST_TRIG,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic rotate;
    logic trig;
    logic mul1;
    logic mul2;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic kick;
    logic last_step;
    logic out_free;
  } sts_t;

  // atan(2^-i) in 2^-14 degree
  function automatic logic signed [23:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [23:0] r;
    unique case (i)
      5'd0:    r = 24'sd737280;
      5'd1:    r = 24'sd435242;
      5'd2:    r = 24'sd229970;
      5'd3:    r = 24'sd116736;
      5'd4:    r = 24'sd58595;
      5'd5:    r = 24'sd29326;
      5'd6:    r = 24'sd14667;
      5'd7:    r = 24'sd7334;
      5'd8:    r = 24'sd3667;
      5'd9:    r = 24'sd1833;
      5'd10:   r = 24'sd917;
      5'd11:   r = 24'sd458;
      5'd12:   r = 24'sd229;
      5'd13:   r = 24'sd115;
      5'd14:   r = 24'sd57;
      5'd15:   r = 24'sd29;
      5'd16:   r = 24'sd14;
      5'd17:   r = 24'sd7;
      5'd18:   r = 24'sd4;
      5'd19:   r = 24'sd2;
      5'd20:   r = 24'sd1;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/lsp_ctrl.sv]
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: takes input words and steps the datapath through one sample.
// ----------------------------------------------------------------------------
module lsp_ctrl import lsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && sts.kick) state_next = ST_PREP;
      end
      ST_PREP:   state_next = ST_ROTATE;
      ST_ROTATE: begin
        if (sts.last_step) state_next = ST_TRIG;
      end
      ST_TRIG:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROUND;
      ST_ROUND: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      ST_PREP:   cmd.load   = 1'b1;
      ST_ROTATE: cmd.rotate = 1'b1;
      ST_TRIG:   cmd.trig   = 1'b1;
      ST_MUL1:   cmd.mul1   = 1'b1;
      ST_MUL2:   cmd.mul2   = 1'b1;
      ST_SUM:    cmd.sum    = 1'b1;
      ST_ROUND:  cmd.emit   = sts.out_free;
      default: ;
    endcase
  end

endmodule

[hw/rtl/lsp_datapath.sv]
// ----------------------------------------------------------------------------
// lsp_datapath
// Config registers, byte framing, iterative CORDIC, scaling and output word.
// ----------------------------------------------------------------------------
module lsp_datapath import lsp_pkg::*; #(
  parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
  parameter int CORDIC_STEPS     = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tuser,
  input  logic [7:0]            s_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,
  output logic                  m_tlast
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [55:0] TRUNC_BIAS = 56'sh00_00FF_FFFF_FFFF;

  logic [7:0]  quality_min;
  logic [11:0] samples_per_scan;
  logic [8:0]  center_x;
  logic [8:0]  center_y;
  logic [19:0] distance_scale;

  logic [DESC_W-1:0] desc_left;
  logic [2:0]        phase;
  logic [31:0]       sample_bytes;
  logic [11:0]       kept_count;
  logic              scan_done;

  logic [14:0] angle;
  logic [15:0] distance;
  logic        last_flag;

  logic [STEP_W-1:0]   step;
  logic signed [32:0]  x, y;
  logic signed [23:0]  z;
  logic                neg;
  logic signed [17:0]  cos_q, sin_q;
  logic signed [34:0]  px1, py1;
  logic signed [55:0]  px2, py2;
  logic signed [55:0]  sx, sy;

  logic [11:0] kept_inc;
  logic [14:0] angle_in;
  logic [14:0] a_mod;
  logic signed [15:0] a_fold;
  logic fold_neg;
  logic signed [32:0] dx, dy;
  logic signed [23:0] atan_i;
  logic signed [10:0] pix_x, pix_y;

  function automatic logic signed [17:0] to_q16(input logic signed [32:0] v,
                                                input logic inv);
    logic signed [33:0] w;
    logic signed [33:0] r;
    w = {v[32], v};
    if (inv) w = -w;
    r = (w + 34'sd8192) >>> 14;
    if (r > 34'(Q16_ONE))       return Q16_ONE;
    else if (r < -34'(Q16_ONE)) return -Q16_ONE;
    else                        return r[17:0];
  endfunction

  function automatic logic signed [10:0] to_pixel(input logic signed [55:0] s);
    logic signed [55:0] t;
    t = (s + (s[55] ? TRUNC_BIAS : 56'sd0)) >>> 40;
    if (t < 56'(PIX_MIN))      return PIX_MIN;
    else if (t > 56'(PIX_MAX)) return PIX_MAX;
    else                       return t[10:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      quality_min      <= QUALITY_MIN_RST;
      samples_per_scan <= SAMPLES_PER_SCAN_RST;
      center_x         <= CENTER_X_RST;
      center_y         <= CENTER_Y_RST;
      distance_scale   <= DISTANCE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUALITY_MIN:      quality_min      <= cfg_data[7:0];
        REG_SAMPLES_PER_SCAN: samples_per_scan <= cfg_data[11:0];
        REG_CENTER_X:         center_x         <= cfg_data[8:0];
        REG_CENTER_Y:         center_y         <= cfg_data[8:0];
        REG_DISTANCE_SCALE:   distance_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // framing
  assign kept_inc = kept_count + 12'd1;
  assign angle_in = 15'(sample_bytes[15:9]) + {sample_bytes[23:16], 7'd0};

  assign sts.kick = !s_tuser && !scan_done && (desc_left == '0) && (phase == 3'd4)
                    && (sample_bytes[7:0] >= quality_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_left    <= '0;
      phase        <= '0;
      sample_bytes <= '0;
      kept_count   <= '0;
      scan_done    <= 1'b1;
    end else if (cmd.take) begin
      if (s_tuser) begin
        desc_left    <= DESC_W'(DESCRIPTOR_BYTES);
        phase        <= '0;
        sample_bytes <= '0;
        kept_count   <= '0;
        scan_done    <= 1'b0;
      end else if (!scan_done) begin
        if (desc_left != '0) begin
          desc_left <= desc_left - DESC_W'(1);
        end else if (phase != 3'd4) begin
          sample_bytes[phase[1:0]*8 +: 8] <= s_tdata;
          phase <= phase + 3'd1;
        end else begin
          phase        <= '0;
          sample_bytes <= '0;
          if (sts.kick) begin
            kept_count <= kept_inc;
            if (kept_inc >= samples_per_scan) scan_done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sts.kick) begin
      angle     <= angle_in;
      distance  <= {s_tdata, sample_bytes[31:24]};
      last_flag <= kept_inc >= samples_per_scan;
    end
  end

  // angle reduction and fold into +/-90 degrees
  always_comb begin
    a_mod    = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
    a_fold   = $signed({1'b0, a_mod});
    fold_neg = 1'b0;
    if (a_mod > QUARTER_TURN && a_mod < THREE_QUARTER) begin
      a_fold   = $signed({1'b0, a_mod}) - $signed({1'b0, HALF_TURN});
      fold_neg = 1'b1;
    end else if (a_mod >= THREE_QUARTER) begin
      a_fold = $signed({1'b0, a_mod}) - $signed({1'b0, FULL_TURN});
    end
  end

  assign dx     = y >>> step;
  assign dy     = x >>> step;
  assign atan_i = atan_lut(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load) begin
      step <= '0;
    end else if (cmd.rotate) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= CORDIC_GAIN_Q30;
      y   <= '0;
      z   <= {a_fold, 8'd0};
      neg <= fold_neg;
    end else if (cmd.rotate) begin
      if (!z[23]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_i;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_i;
      end
    end
    if (cmd.trig) begin
      cos_q <= to_q16(x, neg);
      sin_q <= to_q16(y, neg);
    end
    if (cmd.mul1) begin
      px1 <= cos_q * $signed({1'b0, distance});
      py1 <= sin_q * $signed({1'b0, distance});
    end
    if (cmd.mul2) begin
      px2 <= px1 * $signed({1'b0, distance_scale});
      py2 <= py1 * $signed({1'b0, distance_scale});
    end
    if (cmd.sum) begin
      sx <= px2 + $signed({7'd0, center_x, 40'd0});
      sy <= py2 + $signed({7'd0, center_y, 40'd0});
    end
  end

  assign pix_x = to_pixel(sx);
  assign pix_y = to_pixel(sy);

  assign sts.last_step = (step == LAST_STEP);
  assign sts.out_free  = !m_tvalid || m_tready;

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'd0, distance, angle, pix_y, pix_x};
      m_tlast <= last_flag;
    end
  end

endmodule

[hw/rtl/lidar_sample_to_pixel_unit.sv]
// ----------------------------------------------------------------------------
// lidar_sample_to_pixel_unit
// Throughput: one byte per cycle in idle; a kept sample's last byte blocks the input
// until round emits its word, the shared CORDIC rotator taking one step per cycle.
// Path: prep, rotate, trig, mul1, mul2, sum, round; round waits for a free output.
// Reset: registers to defaults, scan idle until a restart word, output empty.
// ----------------------------------------------------------------------------
module lidar_sample_to_pixel_unit import lsp_pkg::*; #(
  parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
  parameter int CORDIC_STEPS     = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // pixel_x, pixel_y, raw_angle, raw_distance
  output logic                  m_tlast
);

  cmd_t cmd;
  sts_t sts;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsp_datapath #(
    .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES),
    .CORDIC_STEPS     (CORDIC_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

[tb/tb_lidar_sample_to_pixel_unit.sv]
// ----------------------------------------------------------------------------
// tb_lidar_sample_to_pixel_unit
// Feeds rangefinder byte streams (restarts, descriptor bytes, 5-byte samples,
// noise) through the stream input and checks each pixel word against a local
// CORDIC-based predictor. Registers change between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lidar_sample_to_pixel_unit;
  import lsp_pkg::*;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int     SETTLE_CYCLES  = 2 * (CORDIC_STEPS_DEF + 6);
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     HOLD_CYCLES    = 600;
  localparam int     HOLD_AFTER     = 40;
  localparam int     N_PHASES       = 9;
  localparam int     PHASE_BYTES    = 160;
  localparam int     IDLE_PCT       = 28;

  localparam longint ANG_FULL     = 23040;
  localparam longint ANG_HALF     = 11520;
  localparam longint ANG_QUARTER  = 5760;
  localparam longint ANG_3QUARTER = 17280;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint PIX_ONE      = 64'sd1 << 40;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } rx_item_t;

  typedef struct packed {
    logic signed [10:0] px;
    logic signed [10:0] py;
    logic [14:0]        ang;
    logic [15:0]        rng;
    logic               last;
  } pixel_word_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;  // rx_byte
  logic                  s_tuser   = 1'b0;  // op
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [55:0]           m_tdata;   // pixel_x, pixel_y, raw_angle, raw_distance
  logic                  m_tlast;

  always #1 clk = ~clk;

  lidar_sample_to_pixel_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // predictor state and register copy
  logic [7:0]  q_min = QUALITY_MIN_RST;
  logic [11:0] spc   = SAMPLES_PER_SCAN_RST;
  logic [8:0]  cx    = CENTER_X_RST;
  logic [8:0]  cy    = CENTER_Y_RST;
  logic [19:0] scale = DISTANCE_SCALE_RST;
  logic [2:0]  desc_left = '0;
  logic [2:0]  phase     = '0;
  logic [31:0] acc       = '0;
  logic [11:0] kept      = '0;
  logic        done      = 1'b1;

  rx_item_t    pending_q[$];
  pixel_word_t pixel_q[$];
  pixel_word_t pred_w, exp_w, got_w;
  rx_item_t    nxt_item;

  int  errors      = 0;
  int  queued      = 0;
  int  bytes_in    = 0;
  int  words_seen  = 0;
  int  lasts_seen  = 0;
  int  stall_count = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  bit  calm        = 1'b0;

  function automatic longint atan_step(int i);
    case (i)
      0: return 737280;  1: return 435242;  2: return 229970;  3: return 116736;
      4: return 58595;   5: return 29326;   6: return 14667;   7: return 7334;
      8: return 3667;    9: return 1833;    10: return 917;    11: return 458;
      12: return 229;    13: return 115;    14: return 57;     15: return 29;
      16: return 14;     17: return 7;      18: return 4;      19: return 2;
      20: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint to_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic void trig_of(input logic [14:0] ang, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit neg;
    a = longint'(ang) % ANG_FULL;
    neg = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (a > ANG_QUARTER && a < ANG_3QUARTER) begin
      a = a - ANG_HALF;
      neg = 1'b1;
    end else if (a >= ANG_3QUARTER) begin
      a = a - ANG_FULL;
    end
    z = a * 256;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step(i);
      end
    end
    c = to_q16(neg ? -x : x);
    s = to_q16(neg ? -y : y);
  endfunction

  function automatic logic signed [10:0] pixel_of(logic [8:0] ctr, logic [15:0] d, longint trig);
    longint acc_sum, q;
    acc_sum = longint'(ctr) * PIX_ONE + longint'(d) * longint'(scale) * trig;
    q = (acc_sum >= 0) ? (acc_sum >>> 40) : -((-acc_sum) >>> 40);
    if (q < -512) q = -512;
    if (q > 767) q = 767;
    return q[10:0];
  endfunction

  // advances the byte decoder by one word; returns 1 when a pixel comes out
  function automatic bit predict_byte(input rx_item_t it, output pixel_word_t w);
    logic [7:0] b0, b1, b2, b3;
    longint c, s;
    w = '0;
    if (it.op == OP_RESTART) begin
      desc_left = 3'(DESCRIPTOR_BYTES_DEF);
      phase = '0;
      acc = '0;
      kept = '0;
      done = 1'b0;
      return 1'b0;
    end
    if (done) return 1'b0;
    if (desc_left != 0) begin
      desc_left = desc_left - 1'b1;
      return 1'b0;
    end
    if (phase < 4) begin
      acc = acc | (32'(it.b) << (8 * phase));
      phase = phase + 1'b1;
      return 1'b0;
    end
    {b3, b2, b1, b0} = acc;
    phase = '0;
    acc = '0;
    if (b0 < q_min) return 1'b0;
    w.ang = {b2, b1[7:1]};
    w.rng = {it.b, b3};
    kept = kept + 1'b1;
    w.last = (kept >= spc);
    if (w.last) done = 1'b1;
    trig_of(w.ang, c, s);
    w.px = pixel_of(cx, w.rng, c);
    w.py = pixel_of(cy, w.rng, s);
    return 1'b1;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 20)
      $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  task automatic push_item(logic op, logic [7:0] b);
    rx_item_t it;
    it.op = op;
    it.b = b;
    pending_q.push_back(it);
    queued++;
  endtask

  task automatic push_sample(logic [7:0] b0, b1, b2, b3, b4);
    push_item(OP_BYTE, b0);
    push_item(OP_BYTE, b1);
    push_item(OP_BYTE, b2);
    push_item(OP_BYTE, b3);
    push_item(OP_BYTE, b4);
  endtask

  task automatic push_scan_start();
    push_item(OP_RESTART, 8'($urandom()));
    repeat (DESCRIPTOR_BYTES_DEF) push_item(OP_BYTE, 8'($urandom()));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] v, int w);
    logic [19:0] d;
    d = v | 20'($urandom() << w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_QUALITY_MIN:      q_min = d[7:0];
      REG_SAMPLES_PER_SCAN: spc = d[11:0];
      REG_CENTER_X:         cx = d[8:0];
      REG_CENTER_Y:         cy = d[8:0];
      REG_DISTANCE_SCALE:   scale = d[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // scans of well-formed samples with random content, broken up by noise
  task automatic random_phase(int target, bit carry_on);
    int start, nsamp, lim, r;
    logic [7:0]  b0, b1, b2, b4;
    logic [14:0] ang;
    start = queued;
    if (carry_on)
      repeat (3) push_sample(8'($urandom_range(q_min, 255)), 8'($urandom()),
                             8'($urandom()), 8'($urandom()), 8'($urandom()));
    while (queued - start < target) begin
      push_scan_start();
      lim = (spc == 0) ? 1 : int'(spc);
      nsamp = $urandom_range(1, (lim > 28) ? 30 : lim + 2);
      for (int k = 0; k < nsamp; k++) begin
        r = $urandom_range(99);
        if (r < 5) push_item(OP_BYTE, 8'($urandom()));
        else if (r < 8) push_scan_start();
        else if (r < 10) push_item(1'($urandom()), 8'($urandom()));
        b0 = ($urandom_range(99) < 80) ? 8'($urandom_range(q_min, 255)) : 8'($urandom());
        b1 = 8'($urandom());
        b2 = 8'($urandom());
        if ($urandom_range(19) == 0) begin
          case ($urandom_range(4))
            0: ang = 15'(ANG_QUARTER);
            1: ang = 15'(ANG_HALF);
            2: ang = 15'(ANG_3QUARTER);
            3: ang = 15'(ANG_FULL);
            default: ang = 15'h7FFF;
          endcase
          b1 = {ang[6:0], 1'($urandom())};
          b2 = ang[14:7];
        end
        b4 = ($urandom_range(99) < 30) ? 8'($urandom_range(3)) : 8'($urandom());
        push_sample(b0, b1, b2, 8'($urandom()), b4);
      end
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(1, 6)) push_item(OP_BYTE, 8'($urandom()));
    end
  endtask

  // input side: offers queued words and predicts on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        bytes_in <= bytes_in + 1;
        if (predict_byte(rx_item_t'({s_tuser, s_tdata}), pred_w)) pixel_q.push_back(pred_w);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt_item = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt_item.op;
          s_tdata <= nxt_item.b;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_seen >= HOLD_AFTER) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_seen <= words_seen + 1;
      if (m_tlast) lasts_seen <= lasts_seen + 1;
      got_w.px   = m_tdata[10:0];
      got_w.py   = m_tdata[21:11];
      got_w.ang  = m_tdata[36:22];
      got_w.rng  = m_tdata[52:37];
      got_w.last = m_tlast;
      if (pixel_q.size() == 0) begin
        report("word with none expected, angle", got_w.ang, -1);
      end else begin
        exp_w = pixel_q.pop_front();
        if (got_w.px != exp_w.px) report("pixel_x", got_w.px, exp_w.px);
        if (got_w.py != exp_w.py) report("pixel_y", got_w.py, exp_w.py);
        if (got_w.ang != exp_w.ang) report("raw_angle", got_w.ang, exp_w.ang);
        if (got_w.rng != exp_w.rng) report("raw_distance", got_w.rng, exp_w.rng);
        if (got_w.last != exp_w.last) report("last", got_w.last, exp_w.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_count <= 0;
    else stall_count <= stall_count + 1;
  end

  initial begin : watchdog
    while (stall_count < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [19:0] qv, sv, xv, yv, kv;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bytes before any restart are dropped
    push_item(OP_BYTE, 8'h55);
    push_item(OP_BYTE, 8'hAA);
    push_scan_start();
    push_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_sample(8'd7, 8'h00, 8'hFF, 8'h00, 8'hFF);
    push_sample(8'd8, 8'd1, 8'd45, 8'h80, 8'h00);
    wait_idle();

    for (int p = 1; p <= N_PHASES; p++) begin
      case (p)
        1: begin qv = 0; sv = 0; xv = 0; yv = 0; kv = 0; end
        2: begin qv = 255; sv = 4095; xv = 511; yv = 511; kv = 20'hFFFFF; end
        default: begin
          qv = 20'($urandom_range(40));
          sv = (p == 3) ? 20'd1 : 20'($urandom_range(1, 12));
          xv = 20'($urandom_range(511));
          yv = 20'($urandom_range(511));
          kv = ($urandom_range(1) != 0) ? 20'($urandom_range(200000))
                                        : 20'($urandom_range(20'hFFFFF));
        end
      endcase
      write_reg(REG_QUALITY_MIN, qv, 8);
      write_reg(REG_SAMPLES_PER_SCAN, sv, 12);
      write_reg(REG_CENTER_X, xv, 9);
      write_reg(REG_CENTER_Y, yv, 9);
      write_reg(REG_DISTANCE_SCALE, kv, 20);
      for (int j = REG_UNUSED_LO; j <= REG_UNUSED_HI; j++)
        write_reg(CFG_IDX_W'(j), 20'($urandom()), 0);
      calm = (p == 4);
      // phase 3 lowers the count while a scan is open
      random_phase(PHASE_BYTES, p == 3 || $urandom_range(1) == 1);
      wait_idle();
      calm = 1'b0;
    end

    $display("run covered %0d input bytes over %0d register settings", bytes_in, N_PHASES + 1);
    $display("%0d pixel words compared, %0d of them closing a scan", words_seen, lasts_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
